// ===== hw/rtl/wtsc_pkg.sv =====
// shared types and constants for the wave table sound channel
package wtsc_pkg;

    localparam int WAVE_BYTES = 16;
    localparam int WAVE_AW    = 4;
    localparam int IDX_W      = 5;

    localparam logic [15:0] ADDR_DAC     = 16'hFF1A;
    localparam logic [15:0] ADDR_LENGTH  = 16'hFF1B;
    localparam logic [15:0] ADDR_VOLUME  = 16'hFF1C;
    localparam logic [15:0] ADDR_PER_LO  = 16'hFF1D;
    localparam logic [15:0] ADDR_PER_HI  = 16'hFF1E;
    localparam logic [15:0] ADDR_WAVE_LO = 16'hFF30;
    localparam logic [15:0] ADDR_WAVE_HI = 16'hFF3F;

    localparam logic [10:0] PERIOD_MAX   = 11'h7FF;
    localparam logic [7:0]  LENGTH_MAX   = 8'hFF;
    localparam logic [7:0]  UNMAPPED     = 8'hFF;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_CLOCK  = 2'd2,
        OP_LENGTH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        VOL_MUTE    = 2'd0,
        VOL_FULL    = 2'd1,
        VOL_HALF    = 2'd2,
        VOL_QUARTER = 2'd3
    } vol_t;

    typedef struct packed {
        logic               we;
        logic [WAVE_AW-1:0] addr;
        logic [7:0]         data;
    } wr_t;

    typedef struct packed {
        logic [7:0]       read_data;
        logic             channel_on;
        logic [IDX_W-1:0] sample_idx;
        vol_t             vol_code;
    } res_t;

endpackage

// ===== hw/rtl/wtsc_ram.sv =====
// generic ram, one write port and two registered read ports
module wtsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a_reg <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== hw/rtl/wtsc_wave.sv =====
// wave memory with cleared-at-reset valid bits and same-edge write bypass
module wtsc_wave (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wtsc_pkg::wr_t               wr,
    input  logic                        re_a,
    input  logic [wtsc_pkg::WAVE_AW-1:0] raddr_a,
    output logic [7:0]                  rdata_a,
    input  logic                        re_b,
    input  logic [wtsc_pkg::WAVE_AW-1:0] raddr_b,
    output logic [7:0]                  rdata_b
);

    logic [wtsc_pkg::WAVE_BYTES-1:0] valid_reg;
    logic [wtsc_pkg::WAVE_BYTES-1:0] valid_next;
    logic       val_a_reg;
    logic       val_b_reg;
    logic       hit_a_reg;
    logic       hit_b_reg;
    logic [7:0] fwd_a_reg;
    logic [7:0] fwd_b_reg;
    logic [7:0] ram_a;
    logic [7:0] ram_b;

    wtsc_ram #(
        .WIDTH (8),
        .DEPTH (wtsc_pkg::WAVE_BYTES)
    ) u_ram (
        .clk     (clk),
        .we      (wr.we),
        .waddr   (wr.addr),
        .wdata   (wr.data),
        .re_a    (re_a),
        .raddr_a (raddr_a),
        .rdata_a (ram_a),
        .re_b    (re_b),
        .raddr_b (raddr_b),
        .rdata_b (ram_b)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.we)
        begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            val_a_reg <= 1'b0;
            val_b_reg <= 1'b0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (re_a)
            begin
                val_a_reg <= valid_reg[raddr_a];
                hit_a_reg <= wr.we && (wr.addr == raddr_a);
            end
            if (re_b)
            begin
                val_b_reg <= valid_reg[raddr_b];
                hit_b_reg <= wr.we && (wr.addr == raddr_b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            fwd_a_reg <= wr.data;
        end
        if (re_b)
        begin
            fwd_b_reg <= wr.data;
        end
    end

    assign rdata_a = hit_a_reg ? fwd_a_reg : (val_a_reg ? ram_a : 8'd0);
    assign rdata_b = hit_b_reg ? fwd_b_reg : (val_b_reg ? ram_b : 8'd0);

endmodule

// ===== hw/rtl/wtsc_core.sv =====
// channel registers, timers and per-transaction next-state logic
module wtsc_core #(
    parameter int TICK_DIVIDE = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  wtsc_pkg::op_t     op,
    input  logic [15:0]       address,
    input  logic [7:0]        write_data,
    input  logic [7:0]        wave_rdata,
    output wtsc_pkg::wr_t     wave_wr,
    output wtsc_pkg::res_t    res
);

    localparam int DIV_W = (TICK_DIVIDE > 1) ? $clog2(TICK_DIVIDE) : 1;
    localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(TICK_DIVIDE - 1);

    logic [7:0]                 dac_reg,      dac_next;
    logic [7:0]                 len_load_reg, len_load_next;
    logic [7:0]                 volume_reg,   volume_next;
    logic [7:0]                 per_lo_reg,   per_lo_next;
    logic [7:0]                 per_hi_reg,   per_hi_next;
    logic [wtsc_pkg::IDX_W-1:0] idx_reg,      idx_next;
    logic [DIV_W-1:0]           div_reg,      div_next;
    logic [10:0]                pc_reg,       pc_next;
    logic [7:0]                 len_reg,      len_next;
    logic                       len_on_reg,   len_on_next;
    logic                       en_reg,       en_next;
    logic                       trig;
    logic                       is_wave;
    logic [7:0]                 rd;
    logic [10:0]                period;

    always_comb
    begin
        dac_next      = dac_reg;
        len_load_next = len_load_reg;
        volume_next   = volume_reg;
        per_lo_next   = per_lo_reg;
        per_hi_next   = per_hi_reg;
        idx_next      = idx_reg;
        div_next      = div_reg;
        pc_next       = pc_reg;
        len_next      = len_reg;
        len_on_next   = len_on_reg;
        en_next       = en_reg;
        trig          = 1'b0;
        rd            = 8'd0;
        wave_wr.we    = 1'b0;
        wave_wr.addr  = address[wtsc_pkg::WAVE_AW-1:0];
        wave_wr.data  = write_data;
        is_wave       = (address >= wtsc_pkg::ADDR_WAVE_LO) &&
                        (address <= wtsc_pkg::ADDR_WAVE_HI);
        period        = {per_hi_reg[2:0], per_lo_reg};

        case (op)
            wtsc_pkg::OP_READ:
            begin
                case (address)
                    wtsc_pkg::ADDR_DAC:    rd = dac_reg;
                    wtsc_pkg::ADDR_LENGTH: rd = len_load_reg;
                    wtsc_pkg::ADDR_VOLUME: rd = volume_reg;
                    wtsc_pkg::ADDR_PER_LO: rd = per_lo_reg;
                    wtsc_pkg::ADDR_PER_HI: rd = per_hi_reg;
                    default:               rd = is_wave ? wave_rdata : wtsc_pkg::UNMAPPED;
                endcase
            end
            wtsc_pkg::OP_WRITE:
            begin
                case (address)
                    wtsc_pkg::ADDR_DAC:
                    begin
                        dac_next = write_data;
                        trig     = write_data[7];
                        if (!write_data[7])
                        begin
                            en_next = 1'b0;
                        end
                    end
                    wtsc_pkg::ADDR_LENGTH: len_load_next = write_data;
                    wtsc_pkg::ADDR_VOLUME: volume_next   = write_data;
                    wtsc_pkg::ADDR_PER_LO: per_lo_next   = write_data;
                    wtsc_pkg::ADDR_PER_HI:
                    begin
                        per_hi_next = write_data;
                        trig        = write_data[7];
                        if (write_data[6])
                        begin
                            len_on_next = 1'b1;
                            len_next    = len_load_reg;
                        end
                    end
                    default: wave_wr.we = fire && is_wave;
                endcase
            end
            wtsc_pkg::OP_CLOCK:
            begin
                if (en_reg)
                begin
                    if (div_reg == DIV_LAST)
                    begin
                        div_next = '0;
                        if (pc_reg == wtsc_pkg::PERIOD_MAX)
                        begin
                            idx_next = idx_reg + 1'b1;
                            pc_next  = period;
                        end
                        else
                        begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        div_next = div_reg + 1'b1;
                    end
                end
            end
            wtsc_pkg::OP_LENGTH:
            begin
                if (len_on_reg && en_reg)
                begin
                    if (len_reg == wtsc_pkg::LENGTH_MAX)
                    begin
                        len_on_next = 1'b0;
                        en_next     = 1'b0;
                    end
                    else
                    begin
                        len_next = len_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                rd = 8'd0;
            end
        endcase

        // trigger sees the registers as just written
        if (trig && dac_next[7])
        begin
            en_next  = 1'b1;
            pc_next  = {per_hi_next[2:0], per_lo_next};
            idx_next = wtsc_pkg::IDX_W'(1);
        end

        res.read_data  = rd;
        res.channel_on = en_next;
        res.sample_idx = idx_next;
        res.vol_code   = wtsc_pkg::vol_t'(volume_next[6:5]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dac_reg      <= '0;
            len_load_reg <= '0;
            volume_reg   <= '0;
            per_lo_reg   <= '0;
            per_hi_reg   <= '0;
            idx_reg      <= '0;
            div_reg      <= '0;
            pc_reg       <= '0;
            len_reg      <= '0;
            len_on_reg   <= 1'b0;
            en_reg       <= 1'b0;
        end
        else if (fire)
        begin
            dac_reg      <= dac_next;
            len_load_reg <= len_load_next;
            volume_reg   <= volume_next;
            per_lo_reg   <= per_lo_next;
            per_hi_reg   <= per_hi_next;
            idx_reg      <= idx_next;
            div_reg      <= div_next;
            pc_reg       <= pc_next;
            len_reg      <= len_next;
            len_on_reg   <= len_on_next;
            en_reg       <= en_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !en_reg && op == wtsc_pkg::OP_CLOCK |=> $stable(div_reg) && $stable(pc_reg))
        else $error("divider or period moved while channel off");
    a_len_stop: assert property (@(posedge clk) disable iff (!rst_n)
        fire && op == wtsc_pkg::OP_LENGTH && en_reg && len_on_reg &&
        len_reg == wtsc_pkg::LENGTH_MAX |=> !en_reg && !len_on_reg)
        else $error("length end did not stop channel");
    a_trig_idx: assert property (@(posedge clk) disable iff (!rst_n)
        fire && trig && dac_next[7] |=> en_reg && idx_reg == wtsc_pkg::IDX_W'(1))
        else $error("trigger did not restart channel");
`endif

endmodule

// ===== hw/rtl/wave_table_sound_channel.sv =====
// top level of the wave table sound channel: input stage, result stage, wave memory
//
//  channel  | bus                       | contents
//  ---------+---------------------------+------------------------------------------
//  input    | s_tvalid s_tready         | s_tuser: op; s_tdata: address, write_data
//  output   | m_tvalid m_tready         | m_tdata: read_data, sample, channel_on
//
// one transaction per cycle unless m_tready stalls it; input register, then result register
// next state is worked out in one pass from the input register and the timer registers
// rst_n clears all control and channel state and marks the wave memory as all zero
// a stalled result holds in the result stage while one more transaction waits in the input stage
module wave_table_sound_channel #(
    parameter int TICK_DIVIDE = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // read_data[7:0], sample[11:8], channel_on[12], zero[15:13]
);

    logic                 in_valid_reg;
    wtsc_pkg::op_t        op_reg;
    logic [15:0]          addr_reg;
    logic [7:0]           wd_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           read_data_reg;
    logic                 on_reg;
    wtsc_pkg::vol_t       code_reg;
    logic                 nib_low_reg;
    logic                 advance;
    logic                 fire;
    logic                 accept;
    logic [7:0]           wave_rdata_a;
    logic [7:0]           wave_rdata_b;
    logic [3:0]           nib;
    logic [3:0]           sample;
    wtsc_pkg::wr_t        wave_wr;
    wtsc_pkg::res_t       res;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= wtsc_pkg::op_t'(s_tuser);
            addr_reg <= s_tdata[15:0];
            wd_reg   <= s_tdata[23:16];
        end
    end

    wtsc_wave u_wave (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wave_wr),
        .re_a    (accept),
        .raddr_a (s_tdata[wtsc_pkg::WAVE_AW-1:0]),
        .rdata_a (wave_rdata_a),
        .re_b    (fire),
        .raddr_b (res.sample_idx[wtsc_pkg::IDX_W-1:1]),
        .rdata_b (wave_rdata_b)
    );

    wtsc_core #(
        .TICK_DIVIDE (TICK_DIVIDE)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .op         (op_reg),
        .address    (addr_reg),
        .write_data (wd_reg),
        .wave_rdata (wave_rdata_a),
        .wave_wr    (wave_wr),
        .res        (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_data_reg <= res.read_data;
            on_reg        <= res.channel_on;
            code_reg      <= res.vol_code;
            nib_low_reg   <= res.sample_idx[0];
        end
    end

    // upper nibble is the even sample
    assign nib = nib_low_reg ? wave_rdata_b[3:0] : wave_rdata_b[7:4];

    always_comb
    begin
        case (code_reg)
            wtsc_pkg::VOL_FULL:    sample = nib;
            wtsc_pkg::VOL_HALF:    sample = nib >> 1;
            wtsc_pkg::VOL_QUARTER: sample = nib >> 2;
            default:               sample = 4'd0;
        endcase
        if (!on_reg)
        begin
            sample = 4'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, on_reg, sample, read_data_reg};

`ifndef SYNTHESIS
    a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed transaction has no result");
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(addr_reg) && $stable(op_reg))
        else $error("waiting transaction lost or changed");
    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        fire && op_reg != wtsc_pkg::OP_READ |=> read_data_reg == 8'd0)
        else $error("read data not zero for non-read");
    a_sample_on: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11:8] != 4'd0 |-> m_tdata[12])
        else $error("sample out while channel off");
`endif

endmodule
